// ===== rtl/csort_pkg.sv =====
// ----------------------------------------------------------------------------
// Counting sort package
// Shared sizes, codes and control structures of the edge grouping block.
// ----------------------------------------------------------------------------
package csort_pkg;

  localparam int MAX_EDGES = 1024;
  localparam int MAX_NODES = 256;

  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int CNT_W   = $clog2(MAX_EDGES + 1);
  localparam int NODE_W  = $clog2(MAX_NODES + 1);
  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int WALK_W  = (EDGE_AW > NODE_W) ? EDGE_AW : NODE_W;
  localparam int DEST_W  = 8;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 9;

  typedef enum logic [1:0] {
    KIND_OFFSET    = 2'd0,
    KIND_EDGE      = 2'd1,
    KIND_BAD_DEST  = 2'd2,
    KIND_FULL      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_LOAD = 2'd0,
    PH_OFFS = 2'd1,
    PH_EDGE = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_SC_RD,
    ST_SC_CUR,
    ST_SC_WR,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic clr_step;
    logic ld_store;
    logic ld_commit;
    logic rej;
    logic close;
    logic pfx_rd;
    logic pfx_wr;
    logic sc_rd;
    logic sc_cur;
    logic sc_wr;
    logic dr_rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   bad_dest;
    logic   full;
    logic   n_zero;
    logic   tot_zero;
    logic   pfx_last;
    logic   sc_last;
    logic   emit_final;
    logic   clr_last;
  } stat_t;

endpackage

// ===== rtl/csort_ctrl.sv =====
// ----------------------------------------------------------------------------
// Counting sort controller
// Sequences loads, the prefix and scatter walks, draining and clearing.
// ----------------------------------------------------------------------------
module csort_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_op,
  input  csort_pkg::stat_t stat,
  output csort_pkg::cmd_t  cmd,
  output logic            busy
);
  import csort_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (!in_op) begin
            if (stat.phase == PH_LOAD) begin
              if (stat.bad_dest || stat.full) begin
                cmd.rej = 1'b1;
              end else begin
                cmd.ld_store = 1'b1;
                state_nxt    = ST_LD_WR;
              end
            end
          end else if (stat.phase == PH_LOAD) begin
            cmd.close = 1'b1;
            if (!stat.n_zero) begin
              state_nxt = ST_PFX_RD;
            end else if (stat.tot_zero) begin
              state_nxt = ST_DRAIN;
            end else begin
              state_nxt = ST_SC_RD;
            end
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_LD_WR: begin
        cmd.ld_commit = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_PFX_RD: begin
        cmd.pfx_rd = 1'b1;
        state_nxt  = ST_PFX_WR;
      end
      ST_PFX_WR: begin
        cmd.pfx_wr = 1'b1;
        if (!stat.pfx_last) begin
          state_nxt = ST_PFX_RD;
        end else if (stat.tot_zero) begin
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_SC_RD: begin
        cmd.sc_rd = 1'b1;
        state_nxt = ST_SC_CUR;
      end
      ST_SC_CUR: begin
        cmd.sc_cur = 1'b1;
        state_nxt  = ST_SC_WR;
      end
      ST_SC_WR: begin
        cmd.sc_wr = 1'b1;
        state_nxt = stat.sc_last ? ST_DRAIN : ST_SC_RD;
      end
      ST_DRAIN: begin
        cmd.dr_rd = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = stat.emit_final ? ST_CLEAR : ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/csort_dp.sv =====
// ----------------------------------------------------------------------------
// Counting sort datapath
// Edge store, histogram with prefix sums, fill cursors and grouped store.
// ----------------------------------------------------------------------------
module csort_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csort_pkg::cmd_t               cmd,
  output csort_pkg::stat_t              stat,
  input  logic [csort_pkg::DEST_W-1:0]  in_dest_node,
  input  logic [csort_pkg::DATA_W-1:0]  in_edge_ident,
  input  logic [csort_pkg::DATA_W-1:0]  in_prob_pattern,
  input  logic                          cfg_valid,
  input  logic [csort_pkg::CFG_W-1:0]   cfg_node_count,
  output logic                          out_valid,
  output logic [1:0]                    out_kind,
  output logic [csort_pkg::CNT_W-1:0]   out_position,
  output logic [csort_pkg::CNT_W-1:0]   out_offset_value,
  output logic [csort_pkg::DATA_W-1:0]  out_edge_ident,
  output logic [csort_pkg::DATA_W-1:0]  out_prob_pattern,
  output logic                          out_final_flag
);
  import csort_pkg::*;

  localparam int LD_W  = DEST_W + 2 * DATA_W;
  localparam int GRP_W = 2 * DATA_W;

  logic [LD_W-1:0]   ld_mem  [MAX_EDGES];
  logic [CNT_W-1:0]  cnt_mem [MAX_NODES + 1];
  logic [CNT_W-1:0]  cur_mem [MAX_NODES];
  logic [GRP_W-1:0]  grp_mem [MAX_EDGES];

  logic [CFG_W-1:0]  node_count_r;
  logic [CNT_W-1:0]  edge_total_r;
  phase_t            phase_r;
  logic [CNT_W-1:0]  idx_r;
  logic [WALK_W-1:0] walk_r;
  logic [CNT_W-1:0]  acc_r;
  logic [NODE_W-1:0] clr_idx_r;
  logic [NODE_W-1:0] dsel_r;
  logic [DEST_W-1:0] cur_dest_r;
  logic [LD_W-1:0]   ld_rd_r;
  logic [CNT_W-1:0]  cnt_rd_r;
  logic [CNT_W-1:0]  cur_rd_r;
  logic [GRP_W-1:0]  grp_rd_r;

  logic [NODE_W-1:0] n_act;
  logic [CNT_W-1:0]  acc_sum;
  logic              offs_last;
  logic              edge_last;
  logic              emit_final;
  logic              cnt_we;
  logic [NODE_W-1:0] cnt_wa;
  logic [CNT_W-1:0]  cnt_wd;
  logic              cnt_re;
  logic [NODE_W-1:0] cnt_ra;
  logic              cur_we;
  logic [NODE_AW-1:0] cur_wa;
  logic [CNT_W-1:0]  cur_wd;
  logic [DEST_W-1:0] sc_dest;

  assign n_act = (node_count_r > CFG_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                    : NODE_W'(node_count_r);
  assign acc_sum    = acc_r + cnt_rd_r;
  assign offs_last  = (idx_r == CNT_W'(n_act));
  assign edge_last  = ((idx_r + CNT_W'(1)) >= edge_total_r);
  assign emit_final = (phase_r == PH_OFFS) ? (offs_last && (edge_total_r == '0))
                                           : edge_last;
  assign sc_dest    = ld_rd_r[LD_W-1 -: DEST_W];

  always_comb begin
    stat.phase      = phase_r;
    stat.bad_dest   = (NODE_W'(in_dest_node) >= n_act);
    stat.full       = (edge_total_r == CNT_W'(MAX_EDGES));
    stat.n_zero     = (n_act == '0);
    stat.tot_zero   = (edge_total_r == '0);
    stat.pfx_last   = (NODE_W'(walk_r) == n_act);
    stat.sc_last    = ((CNT_W'(walk_r) + CNT_W'(1)) == edge_total_r);
    stat.emit_final = emit_final;
    stat.clr_last   = (clr_idx_r == NODE_W'(MAX_NODES));
  end

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = clr_idx_r;
    cnt_wd = '0;
    if (cmd.clr_step) begin
      cnt_we = 1'b1;
    end else if (cmd.ld_commit) begin
      cnt_we = 1'b1;
      cnt_wa = dsel_r;
      cnt_wd = cnt_rd_r + CNT_W'(1);
    end else if (cmd.pfx_wr) begin
      cnt_we = 1'b1;
      cnt_wa = NODE_W'(walk_r);
      cnt_wd = acc_sum;
    end
    cnt_re = cmd.ld_store || cmd.pfx_rd || cmd.dr_rd;
    cnt_ra = NODE_W'(idx_r);
    if (cmd.ld_store) begin
      cnt_ra = NODE_W'(in_dest_node) + NODE_W'(1);
    end else if (cmd.pfx_rd) begin
      cnt_ra = NODE_W'(walk_r);
    end
    cur_we = 1'b0;
    cur_wa = cur_dest_r;
    cur_wd = cur_rd_r + CNT_W'(1);
    if (cmd.clr_step) begin
      cur_we = (clr_idx_r < NODE_W'(MAX_NODES));
      cur_wa = NODE_AW'(clr_idx_r);
      cur_wd = '0;
    end else if (cmd.pfx_wr) begin
      cur_we = (NODE_W'(walk_r) < NODE_W'(MAX_NODES));
      cur_wa = NODE_AW'(walk_r);
      cur_wd = acc_sum;
    end else if (cmd.sc_wr) begin
      cur_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_store) begin
      ld_mem[EDGE_AW'(edge_total_r)] <= {in_dest_node, in_edge_ident, in_prob_pattern};
    end
    if (cmd.sc_rd) begin
      ld_rd_r <= ld_mem[EDGE_AW'(walk_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_r <= cnt_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    if (cmd.sc_cur) begin
      cur_rd_r <= cur_mem[sc_dest];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_wr) begin
      grp_mem[EDGE_AW'(cur_rd_r)] <= ld_rd_r[GRP_W-1:0];
    end
    if (cmd.dr_rd) begin
      grp_rd_r <= grp_mem[EDGE_AW'(idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_store) begin
      dsel_r <= NODE_W'(in_dest_node) + NODE_W'(1);
    end
    if (cmd.sc_cur) begin
      cur_dest_r <= sc_dest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CFG_W'(MAX_NODES);
      edge_total_r <= '0;
      phase_r      <= PH_LOAD;
      idx_r        <= '0;
      walk_r       <= '0;
      acc_r        <= '0;
      clr_idx_r    <= '0;
    end else begin
      if (cfg_valid && (edge_total_r == '0) && (phase_r == PH_LOAD)) begin
        node_count_r <= cfg_node_count;
      end
      if (cmd.clr_step) begin
        clr_idx_r <= stat.clr_last ? '0 : clr_idx_r + NODE_W'(1);
      end
      if (cmd.ld_commit) begin
        edge_total_r <= edge_total_r + CNT_W'(1);
      end
      if (cmd.close) begin
        phase_r <= PH_OFFS;
        idx_r   <= '0;
        acc_r   <= '0;
        walk_r  <= (n_act == '0) ? '0 : WALK_W'(1);
      end
      if (cmd.pfx_wr) begin
        acc_r  <= acc_sum;
        walk_r <= stat.pfx_last ? '0 : walk_r + WALK_W'(1);
      end
      if (cmd.sc_wr) begin
        walk_r <= walk_r + WALK_W'(1);
      end
      if (cmd.emit) begin
        if (emit_final) begin
          edge_total_r <= '0;
          phase_r      <= PH_LOAD;
          idx_r        <= '0;
        end else if ((phase_r == PH_OFFS) && offs_last) begin
          phase_r <= PH_EDGE;
          idx_r   <= '0;
        end else begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid      <= 1'b0;
      out_final_flag <= 1'b0;
    end else begin
      out_valid      <= cmd.rej || cmd.emit;
      out_final_flag <= cmd.emit && emit_final;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rej) begin
      out_kind         <= stat.bad_dest ? KIND_BAD_DEST : KIND_FULL;
      out_position     <= edge_total_r;
      out_offset_value <= '0;
      out_edge_ident   <= '0;
      out_prob_pattern <= '0;
    end else if (cmd.emit) begin
      out_position <= idx_r;
      if (phase_r == PH_OFFS) begin
        out_kind         <= KIND_OFFSET;
        out_offset_value <= cnt_rd_r;
        out_edge_ident   <= '0;
        out_prob_pattern <= '0;
      end else begin
        out_kind         <= KIND_EDGE;
        out_offset_value <= '0;
        out_edge_ident   <= grp_rd_r[GRP_W-1 -: DATA_W];
        out_prob_pattern <= grp_rd_r[DATA_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/counting_sort_group_by_key.sv =====
// ----------------------------------------------------------------------------
// Counting sort group by key
// Groups loaded graph edges by destination node and drains CSR offsets and
// the grouped edges one result per drain command.
// ----------------------------------------------------------------------------
// A rejected load and a load during draining leave busy low; an accepted load
// reads and then writes the histogram. Each drain command reads the count
// or grouped store and then emits; its result appears on the cycle busy
// falls, but busy stays high after the final result. The first drain of a
// batch first runs the prefix walk node by node and the scatter walk edge
// by edge. After reset and after the final result a clearing pass holds
// busy high. Results must be taken when out_valid strobes.
module counting_sort_group_by_key (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [csort_pkg::DEST_W-1:0]  in_dest_node,
  input  logic [csort_pkg::DATA_W-1:0]  in_edge_ident,
  input  logic [csort_pkg::DATA_W-1:0]  in_prob_pattern,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csort_pkg::CFG_W-1:0]   cfg_node_count,
  output logic                          out_valid,
  output logic [1:0]                    out_kind,
  output logic [csort_pkg::CNT_W-1:0]   out_position,
  output logic [csort_pkg::CNT_W-1:0]   out_offset_value,
  output logic [csort_pkg::DATA_W-1:0]  out_edge_ident,
  output logic [csort_pkg::DATA_W-1:0]  out_prob_pattern,
  output logic                          out_final_flag
);
  import csort_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  csort_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  csort_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_dest_node     (in_dest_node),
    .in_edge_ident    (in_edge_ident),
    .in_prob_pattern  (in_prob_pattern),
    .cfg_valid        (cfg_valid),
    .cfg_node_count   (cfg_node_count),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_position     (out_position),
    .out_offset_value (out_offset_value),
    .out_edge_ident   (out_edge_ident),
    .out_prob_pattern (out_prob_pattern),
    .out_final_flag   (out_final_flag)
  );

endmodule

// ===== rtl/csort_checker.sv =====
// ----------------------------------------------------------------------------
// Counting sort assertions
// Port level checks of the result strobe against the command transfers.
// ----------------------------------------------------------------------------
module csort_assert (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_op,
  input logic                          out_valid,
  input logic [1:0]                    out_kind,
  input logic                          out_final_flag
);
  import csort_pkg::*;

  a_reject_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BAD_DEST || out_kind == KIND_FULL)
      |-> $past(start && !busy && !in_op))
    else $error("Rejection result without a load transfer.");

  a_drain_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_OFFSET || out_kind == KIND_EDGE) |-> $past(busy))
    else $error("Drain result without preceding work.");

  a_final_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_flag |-> busy)
    else $error("No clearing pass after the final result.");

  a_final_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_flag |-> out_valid)
    else $error("Final flag outside a result transfer.");

endmodule

bind counting_sort_group_by_key csort_assert u_csort_assert (.*);
